// File: src/fqk_pkg.sv
`timescale 1ns / 1ps
package fqk_pkg;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 31;
    localparam int HANDLE_W   = 16;
    localparam int ST_W       = 2;
    localparam int DEPTH_DEF  = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch request, arm the key scan
        logic scan;     // step the key scan
        logic head_rd;  // read the oldest slot
        logic finish;   // close the request and register the result
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_stat;

endpackage

// File: src/fqk_ram.sv
`timescale 1ns / 1ps
module fqk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fqk_ctrl.sv
`timescale 1ns / 1ps
module fqk_ctrl
    import fqk_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  t_stat           i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HEAD = 2'd2;
    localparam logic [1:0] S_HDAT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_op == OP_REMOVE || i_op == OP_PEEK) begin
                        n_state = S_HEAD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HDAT;
            end
            S_HDAT: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/fqk_dp.sv
`timescale 1ns / 1ps
module fqk_dp
    import fqk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [OP_W-1:0]            i_op,
    input  logic [KEY_W-1:0]           i_key,
    input  logic [HANDLE_W-1:0]        i_handle,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    output logic                       o_valid,
    output logic [ST_W-1:0]            o_status,
    output logic [KEY_W-1:0]           o_out_key,
    output logic [HANDLE_W-1:0]        o_out_handle,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int EW = KEY_W + HANDLE_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // request
    logic [OP_W-1:0]     r_op;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_handle;

    // queue state
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [AW-1:0] n_tail;
    logic [CW-1:0] n_count;

    // key scan
    logic [AW-1:0] r_scan_slot;
    logic [CW-1:0] r_scan_pos;
    logic          r_cmp_vld;

    // result
    logic                r_valid;
    logic [ST_W-1:0]     r_status;
    logic [KEY_W-1:0]    r_okey;
    logic [HANDLE_W-1:0] r_ohdl;
    logic [CW-1:0]       r_ocount;
    logic [ST_W-1:0]     n_status;
    logic [KEY_W-1:0]    n_okey;
    logic [HANDLE_W-1:0] n_ohdl;

    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [HANDLE_W-1:0] rd_handle;
    logic                hit;
    logic                full;
    logic                scan_issue;

    fqk_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({r_key, r_handle}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key     = ram_rdata[EW-1 -: KEY_W];
    assign rd_handle  = ram_rdata[HANDLE_W-1:0];
    assign ram_raddr  = i_cmd.head_rd ? r_head : r_scan_slot;
    assign hit        = r_cmp_vld && (rd_key == r_key);
    assign full       = (r_count == FULL_CNT);
    assign scan_issue = (r_scan_pos < r_count);

    // the last compare lands in the cycle where the position reaches the count
    assign o_stat.scan_done = hit || !scan_issue;

    assign ram_we = i_cmd.finish && (r_op == OP_INSERT) && !hit && !full;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = ST_OK;
        n_okey   = '0;
        n_ohdl   = '0;
        case (r_op)
            OP_INSERT: begin
                if (hit) begin
                    n_status = ST_DUP;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE, OP_PEEK: begin
                if (r_count == '0) begin
                    n_status = ST_NONE;
                end else begin
                    n_okey = rd_key;
                    n_ohdl = rd_handle;
                    if (r_op == OP_REMOVE) begin
                        n_head  = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            OP_SEARCH: begin
                if (hit) begin
                    n_okey = rd_key;
                    n_ohdl = rd_handle;
                end else begin
                    n_status = ST_NONE;
                end
            end
            default: begin
                n_status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= scan_issue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_key       <= i_key;
            r_handle    <= i_handle;
            r_scan_slot <= r_head;
            r_scan_pos  <= '0;
        end else if (i_cmd.scan && scan_issue) begin
            r_scan_slot <= (r_scan_slot == LAST_SLOT) ? '0 : r_scan_slot + 1'b1;
            r_scan_pos  <= r_scan_pos + 1'b1;
        end
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_okey   <= n_okey;
            r_ohdl   <= n_ohdl;
            r_ocount <= n_count;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_out_key    = r_okey;
    assign o_out_handle = r_ohdl;
    assign o_count      = r_ocount;
    assign o_is_empty   = (r_ocount == '0);

endmodule

// File: src/fifo_queue_unique_key.sv
`timescale 1ns / 1ps
// First-in first-out queue of up to DEPTH key/handle entries with unique keys.
// A request is taken when start is high and busy is low; its one result shows
// on the o_ ports for a single cycle with o_valid high and must be captured
// then, since the block cannot be held off. Insert and search walk the stored
// keys from the oldest through the single read port of the entry RAM, one key
// per cycle, and stop early on a key match. Remove and peek read the oldest
// slot. Busy drops in the strobe cycle, so the next request may be issued
// alongside the result.
module fifo_queue_unique_key
    import fqk_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            i_op,
    input  logic [KEY_W-1:0]           i_key,
    input  logic [HANDLE_W-1:0]        i_handle,
    output logic                       o_valid,
    output logic [ST_W-1:0]            o_status,
    output logic [KEY_W-1:0]           o_out_key,
    output logic [HANDLE_W-1:0]        o_out_handle,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_is_empty
);

    t_cmd  cmd;
    t_stat stat;

    fqk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    fqk_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_handle     (i_handle),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_out_key    (o_out_key),
        .o_out_handle (o_out_handle),
        .o_count      (o_count),
        .o_is_empty   (o_is_empty)
    );

endmodule
